// File: src/bis_pkg.sv
// Shared types, codes and defaults of the bounded integer stack unit.
package bis_pkg;

    localparam int DEFAULT_DEPTH = 256;
    localparam int CAP_W = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_POP = 3'd1;
    localparam logic [2:0] CMD_PEEK = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_SEARCH = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } bis_state_t;

    typedef struct packed {
        logic [1:0] status;
        logic signed [31:0] data_out;
        logic [7:0] found_index;
        logic [8:0] count;
    } result_t;

endpackage

// File: src/bis_ram.sv
// Single-port-write, single-port-read stack memory with a registered read.
module bis_ram
    import bis_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    parameter int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/bis_ctrl.sv
// Command sequencer of the stack: count register, memory accesses and search scan.
module bis_ctrl
    import bis_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    parameter int AW = $clog2(DEPTH),
    parameter int CW = $clog2(DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] data_in,
    input  logic [CAP_W-1:0]   capacity,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [31:0]        ram_wdata,
    output logic               ram_re,
    output logic [AW-1:0]      ram_raddr,
    input  logic [31:0]        ram_rdata
);

    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    bis_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0] key_reg, key_next;
    result_t res_reg, res_next;

    logic accept;
    logic is_full;
    logic is_empty;
    logic scan_hit;
    logic scan_last;
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] eff_cap;
    logic [CMPW-1:0] count_ext;
    logic [CMPW-1:0] idx_ext;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] idx_inc;

    // Shared decode used by the state, output and datapath blocks.
    always_comb
    begin
        accept = in_valid && (state_reg == S_IDLE);
        cap_ext = CMPW'(capacity);
        eff_cap = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
        count_ext = CMPW'(count_reg);
        idx_ext = CMPW'(idx_reg);
        is_full = (count_ext >= eff_cap);
        is_empty = (count_reg == '0);
        cnt_m1 = count_reg - CW'(1);
        idx_inc = CW'(idx_reg) + CW'(1);
        scan_hit = (ram_rdata == key_reg);
        scan_last = (idx_inc == count_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DONE;
                    if ((cmd == CMD_POP || cmd == CMD_PEEK) && !is_empty)
                    begin
                        state_next = S_READ;
                    end
                    else if (cmd == CMD_SEARCH && !is_empty)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake and memory controls.
    always_comb
    begin
        in_ready = 1'b0;
        res_valid = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = data_in;
        ram_raddr = cnt_m1[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (cmd == CMD_SEARCH)
                begin
                    ram_raddr = '0;
                end
                if (accept)
                begin
                    ram_we = (cmd == CMD_PUSH) && !is_full;
                    ram_re = !is_empty &&
                             (cmd == CMD_POP || cmd == CMD_PEEK || cmd == CMD_SEARCH);
                end
            end
            S_SCAN:
            begin
                ram_raddr = idx_inc[AW-1:0];
                ram_re = !scan_hit && !scan_last;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        logic [CMPW-1:0] count_wide;
        count_wide = '0;
        count_next = count_reg;
        idx_next = idx_reg;
        key_next = key_reg;
        res_next = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next.status = ST_OK;
                    res_next.data_out = '0;
                    res_next.found_index = '0;
                    idx_next = '0;
                    key_next = data_in;
                    case (cmd)
                        CMD_PUSH:
                        begin
                            if (is_full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            if (is_empty)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else if (cmd == CMD_POP)
                            begin
                                count_next = cnt_m1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                res_next.status = ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    count_wide = CMPW'(count_next);
                    res_next.count = count_wide[8:0];
                end
            end
            S_READ:
            begin
                res_next.data_out = $signed(ram_rdata);
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    res_next.found_index = idx_ext[7:0];
                end
                else if (scan_last)
                begin
                    res_next.status = ST_NOTFOUND;
                end
                else
                begin
                    idx_next = idx_inc[AW-1:0];
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

    // The count never exceeds the memory depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stack count above depth");

    // A scan only visits entries below the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(idx_reg) < count_reg))
        else $error("scan index beyond count");

    // A push that is taken raises the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not advance count");

    // Memory writes happen only in the cycle a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (accept && state_reg == S_IDLE))
        else $error("memory write outside request acceptance");

endmodule

// File: src/bounded_integer_stack_unit.sv
// Top level of the bounded integer stack unit: capacity register, output register.
//
// A request carries cmd (push, pop, peek, clear, search) and data_in, and is
// taken when in_valid and in_ready are both high. Every request yields exactly
// one response on status, data_out, found_index and count, offered with
// out_valid and taken when out_ready is high. Requests are handled one at a
// time; in_ready is high only while the sequencer is idle.
// Sequencer path per request: push, clear, refused commands and unused codes go
// straight to the response; pop and peek pass a read state for the registered
// memory read; search on a non-empty stack scans one entry a cycle until a match
// or the last entry. The response is registered in the sequencer, then handed to
// the output register. A response that waits in the output register does not
// block the next request; a second finished response is held in the sequencer
// until the output register frees. The capacity register is written with cfg_we
// and cfg_wdata, only while idle: the user is bound to this, as the block does
// not enforce it. Reset empties the stack, sets capacity to 256 and drops
// out_valid; the stack memory itself is not cleared, as entries are read only
// after being pushed.
module bounded_integer_stack_unit
    import bis_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] data_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] data_out,
    output logic [7:0]         found_index,
    output logic [8:0]         count,
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    result_t res;
    logic res_valid;
    logic res_ready;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0] ram_wdata;
    logic ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0] ram_rdata;

    bis_ctrl #(
        .DEPTH(DEPTH),
        .AW(AW),
        .CW(CW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .data_in(data_in),
        .capacity(capacity_reg),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .ram_we(ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_re(ram_re),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata)
    );

    bis_ram #(
        .DEPTH(DEPTH),
        .AW(AW)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // The output register takes a new response when it is empty or being drained.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        capacity_next = cfg_we ? cfg_wdata : capacity_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_next = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign status = out_reg.status;
    assign data_out = out_reg.data_out;
    assign found_index = out_reg.found_index;
    assign count = out_reg.count;

    // A response handed over by the sequencer is always presented next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> out_valid)
        else $error("handed-over response not presented");

    // The sequencer never takes a request while a response is still pending in it.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !in_ready)
        else $error("request taken while response pending");

endmodule

// File: bench/tb_bounded_integer_stack_unit.sv
// Self-checking testbench for the bounded integer stack unit: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_bounded_integer_stack_unit;
    import bis_pkg::*;

    // The block is built with its default depth, so the bench uses the same one.
    localparam int STACK_DEPTH = DEFAULT_DEPTH;

    // Command codes that the block must treat as a no-operation.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // Every request yields one response, so a drained queue means the block is idle.
    // A margin of SETTLE_CYCLES still passes before a capacity write.
    localparam int SETTLE_CYCLES = 8;

    // The longest request is a search over a full stack, which scans every entry.
    // After the last response the bench waits this long for any stray response.
    localparam int END_WAIT_CYCLES = STACK_DEPTH + 40;

    // The worst correct run is roughly 1800 full-depth searches, each also waiting out
    // long sender gaps and receiver stalls. The limit is taken several times over the
    // length of such a run.
    localparam longint CYCLE_LIMIT = 3_000_000;

    localparam int NUM_PHASES = 5;

    // One row of the directed table: either a capacity write or a request. A request
    // row has its response typed in where it can be read off at a glance. Otherwise
    // the predictor supplies the response.
    typedef struct packed {
        logic        is_cap_write;
        logic        has_typed;
        logic [2:0]  op;
        logic [31:0] arg;
        result_t     want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         cmd;
    logic signed [31:0] data_in;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic [7:0]         found_index;
    logic [8:0]         count;
    logic               cfg_we;
    logic [CAP_W-1:0]   cfg_wdata;

    // Shadow copy of the stack, its fill level and the capacity register.
    logic [31:0]      shadow_mem [STACK_DEPTH];
    int unsigned      shadow_depth;
    logic [CAP_W-1:0] shadow_cap;

    // Responses that are expected but have not yet been seen, oldest first.
    result_t awaited_responses [$];
    result_t head_response;

    int          mismatch_count;
    longint      cycle_count = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          growing;
    logic [31:0] value_pool [8];
    stim_row_t   dir_table [$];
    int          phase_cap [NUM_PHASES];
    int          phase_send_idle [NUM_PHASES];
    int          phase_recv_stall [NUM_PHASES];
    int          phase_items [NUM_PHASES];

    bounded_integer_stack_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .data_out    (data_out),
        .found_index (found_index),
        .count       (count),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always #5 clk = ~clk;

    // The capacity in force. A register value above the depth saturates to the depth.
    function automatic int unsigned capacity_limit();
        return (shadow_cap > STACK_DEPTH) ? STACK_DEPTH : int'(shadow_cap);
    endfunction

    // Applies one request to the shadow stack and returns the response it must produce.
    function automatic result_t stack_op_outcome(input logic [2:0] op, input logic [31:0] word);
        result_t res;
        res = '0;
        case (op)
            CMD_PUSH:
            begin
                // A push is refused while the stack holds as much as the capacity allows.
                // This also holds when the capacity was lowered below the fill level.
                if (shadow_depth >= capacity_limit())
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    shadow_mem[shadow_depth] = word;
                    shadow_depth++;
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                if (shadow_depth == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.data_out = shadow_mem[shadow_depth - 1];
                    if (op == CMD_POP)
                    begin
                        shadow_depth--;
                    end
                end
            end
            CMD_CLEAR:
            begin
                shadow_depth = 0;
            end
            CMD_SEARCH:
            begin
                // The scan runs from the bottom of the stack, so the lowest match wins.
                res.status = ST_NOTFOUND;
                for (int i = 0; i < shadow_depth; i++)
                begin
                    if (shadow_mem[i] == word)
                    begin
                        res.status = ST_OK;
                        res.found_index = 8'(i);
                        break;
                    end
                end
            end
            default:
            begin
                // An unused code changes nothing and answers status OK with zero data and index.
            end
        endcase
        res.count = 9'(shadow_depth);
        return res;
    endfunction

    // Data words mix a small pool, which gives duplicate keys, with the extremes
    // and fully random values.
    function automatic logic [31:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
        begin
            return value_pool[$urandom_range(0, 7)];
        end
        if (roll == 4)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic stim_row_t req_row(input logic [2:0] op, input logic [31:0] arg);
        stim_row_t row;
        row = '0;
        row.op = op;
        row.arg = arg;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [2:0] op, input logic [31:0] arg,
                                            input logic [1:0] st, input logic [31:0] dout,
                                            input logic [7:0] idx, input logic [8:0] cnt);
        stim_row_t row;
        row = req_row(op, arg);
        row.has_typed = 1'b1;
        row.want.status = st;
        row.want.data_out = dout;
        row.want.found_index = idx;
        row.want.count = cnt;
        return row;
    endfunction

    function automatic stim_row_t cap_row(input logic [CAP_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.is_cap_write = 1'b1;
        row.arg = 32'(value);
        return row;
    endfunction

    // Offers one request and returns at the rising edge that takes it. The expected
    // response is queued first. Requests leave in order, so queue order matches
    // acceptance order. Inputs change only at falling edges. in_valid stays high
    // from one request straight into the next unless the sender idles in between.
    task automatic send_request(input logic [2:0] op, input logic [31:0] word,
                                input logic has_typed, input result_t want);
        result_t predicted;
        predicted = stack_op_outcome(op, word);
        awaited_responses.push_back(has_typed ? want : predicted);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        data_in <= word;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Withdraws the request line and waits until every expected response is back.
    task automatic drain_responses();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The capacity register is written only once the block has gone idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_responses();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_cap = value;
    endtask

    // Random traffic follows a fill/drain rhythm so that the stack regularly reaches
    // both full and empty. Searches often use keys that are in the stack, and
    // duplicates come from the value pool, so hits, misses and lowest-index
    // matches all occur.
    task automatic run_random_phase(input int n_items);
        logic [2:0]  op;
        logic [31:0] word;
        int unsigned roll;
        for (int k = 0; k < n_items; k++)
        begin
            // Now and then the sender holds off until every response has arrived.
            if ($urandom_range(0, 149) == 0)
            begin
                drain_responses();
            end
            roll = $urandom_range(0, 999);
            if (roll < 20)
            begin
                op = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            end
            else if (roll < 200)
            begin
                op = CMD_SEARCH;
            end
            else if (roll < 280)
            begin
                op = CMD_PEEK;
            end
            else if (!growing && roll < 300)
            begin
                op = CMD_CLEAR;
            end
            else if (growing)
            begin
                op = (roll < 950) ? CMD_PUSH : CMD_POP;
            end
            else
            begin
                op = (roll < 400) ? CMD_PUSH : CMD_POP;
            end

            word = pick_word();
            if (op == CMD_SEARCH && shadow_depth > 0 && $urandom_range(0, 9) < 6)
            begin
                word = shadow_mem[$urandom_range(0, shadow_depth - 1)];
            end

            // Switch direction at the ends of the range. A few refused pushes come first;
            // a refused pop or a clear turns at once. An occasional random switch gives
            // mid-range turns as well.
            if (op == CMD_PUSH && shadow_depth >= capacity_limit())
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    growing = 1'b0;
                end
            end
            else if ((op == CMD_POP && shadow_depth == 0) || op == CMD_CLEAR)
            begin
                growing = 1'b1;
            end
            else if ($urandom_range(0, 299) == 0)
            begin
                growing = !growing;
            end

            send_request(op, word, 1'b0, '0);
        end
    endtask

    // The receiver's ready line is redrawn at every falling edge. The stall rate is
    // set per phase.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Each response taken at a rising edge is compared field by field with the
    // oldest expectation. A response that nobody expects is a failure too.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                $error("response with nothing expected: status %0d data_out %0d count %0d",
                       status, data_out, count);
                mismatch_count++;
            end
            else
            begin
                head_response = awaited_responses.pop_front();
                if (status !== head_response.status)
                begin
                    $error("status: expected %0d, got %0d", head_response.status, status);
                    mismatch_count++;
                end
                if (data_out !== head_response.data_out)
                begin
                    $error("data_out: expected %0d, got %0d",
                           head_response.data_out, data_out);
                    mismatch_count++;
                end
                if (found_index !== head_response.found_index)
                begin
                    $error("found_index: expected %0d, got %0d",
                           head_response.found_index, found_index);
                    mismatch_count++;
                end
                if (count !== head_response.count)
                begin
                    $error("count: expected %0d, got %0d", head_response.count, count);
                    mismatch_count++;
                end
            end
        end
    end

    // The watchdog ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_PUSH;
        data_in = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = CAP_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_depth = 0;
        shadow_cap = CAP_RESET;
        growing = 1'b1;
        mismatch_count = 0;
        foreach (value_pool[i])
        begin
            value_pool[i] = $urandom();
        end

        // Phase plan. A full stack at the reset capacity comes first. The capacity
        // is then lowered below the fill level. A saturating setting follows, then
        // zero capacity, then a mid value. The idling mix changes with each phase.
        phase_cap        = '{256, 3, 511, 0, 130};
        phase_send_idle  = '{0, 77, 0, 19, 0};
        phase_recv_stall = '{0, 0, 77, 19, 0};
        phase_items      = '{550, 250, 450, 200, 300};

        // The directed table covers the following:
        //   - requests on the empty stack after reset;
        //   - pushes of the data extremes, with a duplicate entry;
        //   - a search hit at the lowest index, and a search miss;
        //   - peek and pop of the top entry;
        //   - the unused command codes;
        //   - a capacity below the fill level, where pushes are refused but pops work;
        //   - zero capacity;
        //   - clear;
        //   - a capacity value above the depth.
        dir_table = '{
            typed_row(CMD_POP,    32'h0000_0000, ST_EMPTY,    32'h0, 8'd0, 9'd0),
            typed_row(CMD_PEEK,   32'h0000_0000, ST_EMPTY,    32'h0, 8'd0, 9'd0),
            typed_row(CMD_SEARCH, 32'h0000_0000, ST_NOTFOUND, 32'h0, 8'd0, 9'd0),
            typed_row(CMD_PUSH,   32'h7FFF_FFFF, ST_OK,       32'h0, 8'd0, 9'd1),
            typed_row(CMD_PUSH,   32'h8000_0000, ST_OK,       32'h0, 8'd0, 9'd2),
            req_row(CMD_PUSH,   32'hFFFF_FFFF),
            req_row(CMD_PUSH,   32'h0000_0000),
            req_row(CMD_PUSH,   32'h7FFF_FFFF),
            typed_row(CMD_SEARCH, 32'h7FFF_FFFF, ST_OK,       32'h0, 8'd0, 9'd5),
            req_row(CMD_SEARCH, 32'h8000_0000),
            typed_row(CMD_SEARCH, 32'h0001_2345, ST_NOTFOUND, 32'h0, 8'd0, 9'd5),
            typed_row(CMD_PEEK,   32'h0000_0000, ST_OK, 32'h7FFF_FFFF, 8'd0, 9'd5),
            typed_row(CMD_POP,    32'hFFFF_FFFF, ST_OK, 32'h7FFF_FFFF, 8'd0, 9'd4),
            typed_row(CMD_UNUSED_LO, 32'hAAAA_AAAA, ST_OK,    32'h0, 8'd0, 9'd4),
            typed_row(CMD_UNUSED_HI, 32'h5555_5555, ST_OK,    32'h0, 8'd0, 9'd4),
            cap_row(9'd2),
            typed_row(CMD_PUSH,   32'h0000_0001, ST_FULL,     32'h0, 8'd0, 9'd4),
            req_row(CMD_POP,    32'h0000_0000),
            req_row(CMD_POP,    32'h0000_0000),
            cap_row(9'd0),
            typed_row(CMD_PUSH,   32'h0000_0000, ST_FULL,     32'h0, 8'd0, 9'd2),
            req_row(CMD_SEARCH, 32'h8000_0000),
            typed_row(CMD_CLEAR,  32'hFFFF_FFFF, ST_OK,       32'h0, 8'd0, 9'd0),
            typed_row(CMD_POP,    32'h0000_0000, ST_EMPTY,    32'h0, 8'd0, 9'd0),
            cap_row(9'd511),
            req_row(CMD_PUSH,   32'h0000_002A),
            req_row(CMD_SEARCH, 32'h0000_002A)
        };

        // Reset is held low from the start and released at a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
        begin
            if (dir_table[i].is_cap_write)
            begin
                write_capacity(dir_table[i].arg[CAP_W-1:0]);
            end
            else
            begin
                send_request(dir_table[i].op, dir_table[i].arg,
                             dir_table[i].has_typed, dir_table[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(CAP_W'(phase_cap[p]));
            send_idle_pct = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            run_random_phase(phase_items[p]);
        end

        // Wait for the last responses, then stay a while longer to catch extra ones.
        drain_responses();
        repeat (END_WAIT_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
